@@ hw/rtl/assert_macros.svh @@
// assertion helpers shared by the rtl files
// each use expects clk and arst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/gbcm_pkg.sv @@
package gbcm_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int GRID_DEPTH  = MAX_COLUMNS * MAX_ROWS;
	localparam int CNT_W       = 7;
	localparam int VAL_W       = 16;
	localparam int FRAC_W      = 8;
	localparam int WGT_W       = 2 * FRAC_W + 1;
	localparam int SUM_W       = 34;
	localparam int OUTQ_DEPTH  = 4;
	localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);
	localparam int CFG_IDX_W   = 2;
	localparam int S_DATA_W    = 80;
	localparam int M_DATA_W    = 2 * VAL_W;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;

	localparam logic [CNT_W-1:0] COLUMNS_RESET = CNT_W'(MAX_COLUMNS);
	localparam logic [CNT_W-1:0] ROWS_RESET    = CNT_W'(MAX_ROWS);

	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (2 * FRAC_W - 1);
	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// read control that travels alongside the memory read data
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic             oor;
		logic [WGT_W-1:0] weight;
	} rd_ctl_t;

	typedef struct packed {
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] x;
		logic             oor;
	} result_t;

	// zero acts as one, anything past the grid size saturates
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] maxv);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// round half up, drop the weight fraction, saturate to the value width
	function automatic logic [VAL_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0]   b;
		logic [SUM_W-2*FRAC_W-1:0] r;
		logic [VAL_W-1:0]          o;
		b = s + ROUND_HALF;
		r = b[SUM_W-1:2*FRAC_W];
		if ((&r[SUM_W-2*FRAC_W-1:VAL_W-1]) || !(|r[SUM_W-2*FRAC_W-1:VAL_W-1])) begin
			o = r[VAL_W-1:0];
		end else if (r[SUM_W-2*FRAC_W-1]) begin
			o = VAL_MIN;
		end else begin
			o = VAL_MAX;
		end
		return o;
	endfunction

endpackage

@@ hw/rtl/gbcm_ram.sv @@
module gbcm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

@@ hw/rtl/gbcm_seq.sv @@
`include "assert_macros.svh"

module gbcm_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          cmd,
	input  logic [gbcm_pkg::COL_W-1:0]    node_column,
	input  logic [gbcm_pkg::ROW_W-1:0]    node_row,
	input  logic [gbcm_pkg::VAL_W-1:0]    node_x_value,
	input  logic [gbcm_pkg::VAL_W-1:0]    node_y_value,
	input  logic [gbcm_pkg::VAL_W-1:0]    query_x,
	input  logic [gbcm_pkg::VAL_W-1:0]    query_y,
	input  logic [gbcm_pkg::CNT_W-1:0]    columns_in_use,
	input  logic [gbcm_pkg::CNT_W-1:0]    rows_in_use,
	output logic                          free,
	output logic                          mem_en,
	output logic                          mem_we,
	output logic [gbcm_pkg::ADDR_W-1:0]   mem_addr,
	output logic [gbcm_pkg::VAL_W-1:0]    mem_wdata_x,
	output logic [gbcm_pkg::VAL_W-1:0]    mem_wdata_y,
	output gbcm_pkg::rd_ctl_t             ctl_s1
);
	import gbcm_pkg::*;

	localparam int AXIS_W = VAL_W - 1;

	logic                busy_q;
	logic                op_q;
	logic [1:0]          step_q;
	logic [COL_W-1:0]    col_lo_q, col_hi_q;
	logic [ROW_W-1:0]    row_lo_q, row_hi_q;
	logic [FRAC_W-1:0]   fu_q, fv_q;
	logic                oor_q;
	logic [VAL_W-1:0]    wx_q, wy_q;

	logic [CNT_W-1:0]    nx, ny, nx_m1, ny_m1, ul_p1, vl_p1;
	logic [AXIS_W-1:0]   hi_x, hi_y, cq_x, cq_y;
	logic                neg_x, neg_y, over_x, over_y;
	logic [COL_W-1:0]    ul, ur;
	logic [ROW_W-1:0]    vl, vr;
	logic [FRAC_W:0]     wa, wb;
	logic [WGT_W-1:0]    weight;
	logic                last_step;

	// clamp both axes into the grid in use
	always_comb begin
		nx     = eff_count(columns_in_use, CNT_W'(MAX_COLUMNS));
		ny     = eff_count(rows_in_use, CNT_W'(MAX_ROWS));
		nx_m1  = nx - CNT_W'(1);
		ny_m1  = ny - CNT_W'(1);
		hi_x   = AXIS_W'({nx_m1, FRAC_W'(0)});
		hi_y   = AXIS_W'({ny_m1, FRAC_W'(0)});
		neg_x  = query_x[VAL_W-1];
		neg_y  = query_y[VAL_W-1];
		over_x = !neg_x && (query_x[AXIS_W-1:0] > hi_x);
		over_y = !neg_y && (query_y[AXIS_W-1:0] > hi_y);
		cq_x   = neg_x ? '0 : (over_x ? hi_x : query_x[AXIS_W-1:0]);
		cq_y   = neg_y ? '0 : (over_y ? hi_y : query_y[AXIS_W-1:0]);
		ul     = cq_x[FRAC_W+COL_W-1:FRAC_W];
		vl     = cq_y[FRAC_W+ROW_W-1:FRAC_W];
		ul_p1  = CNT_W'(ul) + CNT_W'(1);
		vl_p1  = CNT_W'(vl) + CNT_W'(1);
		ur     = (ul_p1 < nx) ? ul_p1[COL_W-1:0] : nx_m1[COL_W-1:0];
		vr     = (vl_p1 < ny) ? vl_p1[ROW_W-1:0] : ny_m1[ROW_W-1:0];
	end

	assign last_step = (op_q == CMD_WRITE) || (step_q == 2'd3);
	assign free      = !busy_q || last_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= CMD_WRITE;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			op_q   <= cmd;
			step_q <= '0;
		end else if (busy_q) begin
			busy_q <= !last_step;
			step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (cmd == CMD_WRITE) begin
				col_lo_q <= node_column;
				row_lo_q <= node_row;
			end else begin
				col_lo_q <= ul;
				row_lo_q <= vl;
			end
			col_hi_q <= ur;
			row_hi_q <= vr;
			fu_q     <= cq_x[FRAC_W-1:0];
			fv_q     <= cq_y[FRAC_W-1:0];
			oor_q    <= neg_x || neg_y || over_x || over_y;
			wx_q     <= node_x_value;
			wy_q     <= node_y_value;
		end
	end

	// corner order: (ul,vl) (ul,vr) (ur,vl) (ur,vr)
	always_comb begin
		wa          = step_q[1] ? {1'b0, fu_q} : (FRAC_W+1)'(1 << FRAC_W) - {1'b0, fu_q};
		wb          = step_q[0] ? {1'b0, fv_q} : (FRAC_W+1)'(1 << FRAC_W) - {1'b0, fv_q};
		weight      = WGT_W'(wa) * WGT_W'(wb);
		mem_en      = busy_q;
		mem_we      = busy_q && (op_q == CMD_WRITE);
		mem_addr    = {(step_q[0] ? row_hi_q : row_lo_q), (step_q[1] ? col_hi_q : col_lo_q)};
		mem_wdata_x = wx_q;
		mem_wdata_y = wy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= busy_q && (op_q == CMD_QUERY);
			ctl_s1.first  <= (step_q == 2'd0);
			ctl_s1.last   <= (step_q == 2'd3);
			ctl_s1.oor    <= oor_q;
			ctl_s1.weight <= weight;
		end
	end

	`ASSERT_NEXT(a_query_starts_fresh, accept && (cmd == CMD_QUERY),
		busy_q && (step_q == 2'd0) && !free)

endmodule

@@ hw/rtl/gbcm_mac.sv @@
module gbcm_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gbcm_pkg::rd_ctl_t          ctl_s1,
	input  logic [gbcm_pkg::VAL_W-1:0] rdata_x,
	input  logic [gbcm_pkg::VAL_W-1:0] rdata_y,
	output logic                       push,
	output gbcm_pkg::result_t          result
);
	import gbcm_pkg::*;

	logic                     valid_s2, first_s2, last_s2, oor_s2;
	logic signed [SUM_W-1:0]  px_s2, py_s2;
	logic signed [SUM_W-1:0]  acc_x_q, acc_y_q;
	logic                     valid_s3, oor_s3;
	logic signed [SUM_W-1:0]  sx_s3, sy_s3;
	logic signed [SUM_W-1:0]  base_x, base_y;

	// one corner product per cycle for each table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= ctl_s1.valid;
			valid_s3 <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s2 <= ctl_s1.first;
		last_s2  <= ctl_s1.last;
		oor_s2   <= ctl_s1.oor;
		px_s2    <= $signed(rdata_x) * $signed({1'b0, ctl_s1.weight});
		py_s2    <= $signed(rdata_y) * $signed({1'b0, ctl_s1.weight});
	end

	assign base_x = first_s2 ? '0 : acc_x_q;
	assign base_y = first_s2 ? '0 : acc_y_q;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_x_q <= base_x + px_s2;
			acc_y_q <= base_y + py_s2;
		end
		if (valid_s2 && last_s2) begin
			sx_s3  <= base_x + px_s2;
			sy_s3  <= base_y + py_s2;
			oor_s3 <= oor_s2;
		end
	end

	assign push       = valid_s3;
	assign result.x   = round_sat(sx_s3);
	assign result.y   = round_sat(sy_s3);
	assign result.oor = oor_s3;

endmodule

@@ hw/rtl/gbcm_outq.sv @@
`include "assert_macros.svh"

module gbcm_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gbcm_pkg::result_t push_data,
	input  logic              pop,
	output logic              not_empty,
	output gbcm_pkg::result_t head
);
	import gbcm_pkg::*;

	result_t                entry_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [OUTQ_CNT_W-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign not_empty = (cnt_q != '0);
	assign head      = entry_q[rd_ptr_q];

	`ASSERT_ALWAYS(a_no_overflow, !(push && !pop && (cnt_q == OUTQ_CNT_W'(OUTQ_DEPTH))))
	`ASSERT_ALWAYS(a_no_underflow, !(pop && (cnt_q == '0)))

endmodule

@@ hw/rtl/grid_bilinear_coord_map.sv @@
// grid bilinear coordinate map: two grid tables with bilinear lookup
// query path: corner reads, weighted products, sum, round and saturate, result queue
// a query item holds the single port of each grid memory for its four corner reads,
// a write item for its one write; the next item waits for the port and a result slot
// reset: control state clears and both count registers return to 64;
// grid memories are not cleared, an entry must be written before it is read
`include "assert_macros.svh"

module grid_bilinear_coord_map (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// node_column, node_row, node_x_value, node_y_value, query_x, query_y, zero fill
	input  logic [gbcm_pkg::S_DATA_W-1:0]     s_axis_tdata,
	// cmd
	input  logic                              s_axis_tuser,
	// result items
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// mapped_x, mapped_y
	output logic [gbcm_pkg::M_DATA_W-1:0]     m_axis_tdata,
	// out_of_range
	output logic                              m_axis_tuser,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gbcm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gbcm_pkg::CNT_W-1:0]        cfg_data
);
	import gbcm_pkg::*;

	// config registers
	logic [CNT_W-1:0]      columns_q, rows_q;

	// input field unpack
	logic [COL_W-1:0]      node_column;
	logic [ROW_W-1:0]      node_row;
	logic [VAL_W-1:0]      node_x_value, node_y_value, query_x, query_y;

	// handshakes and credit count of queries not yet delivered
	logic                  s_accept, m_accept, query_accept;
	logic [OUTQ_CNT_W-1:0] pending_q;
	logic                  seq_free;

	// memory port
	logic                  mem_en, mem_we;
	logic [ADDR_W-1:0]     mem_addr;
	logic [VAL_W-1:0]      wdata_x, wdata_y, rdata_x, rdata_y;

	rd_ctl_t               ctl_s1;
	logic                  push;
	result_t               push_data, head;

	assign node_column  = s_axis_tdata[5:0];
	assign node_row     = s_axis_tdata[11:6];
	assign node_x_value = s_axis_tdata[27:12];
	assign node_y_value = s_axis_tdata[43:28];
	assign query_x      = s_axis_tdata[59:44];
	assign query_y      = s_axis_tdata[75:60];

	// the queue has a slot for every query in flight, so the pipe never stalls
	assign s_axis_tready = seq_free && (pending_q < OUTQ_CNT_W'(OUTQ_DEPTH));
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign query_accept  = s_accept && (s_axis_tuser == CMD_QUERY);
	assign m_accept      = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + OUTQ_CNT_W'(query_accept) - OUTQ_CNT_W'(m_accept);
		end
	end

	// config writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q    <= ROWS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLUMNS: begin
					columns_q <= cfg_data;
				end
				REG_ROWS: begin
					rows_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// clamp, corner addressing and weight generation
	gbcm_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (s_accept),
		.cmd            (s_axis_tuser),
		.node_column    (node_column),
		.node_row       (node_row),
		.node_x_value   (node_x_value),
		.node_y_value   (node_y_value),
		.query_x        (query_x),
		.query_y        (query_y),
		.columns_in_use (columns_q),
		.rows_in_use    (rows_q),
		.free           (seq_free),
		.mem_en         (mem_en),
		.mem_we         (mem_we),
		.mem_addr       (mem_addr),
		.mem_wdata_x    (wdata_x),
		.mem_wdata_y    (wdata_y),
		.ctl_s1         (ctl_s1)
	);

	// grid tables, addressed column + row * MAX_COLUMNS
	gbcm_ram #(.WIDTH(VAL_W), .DEPTH(GRID_DEPTH)) u_grid_x (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (wdata_x),
		.rdata (rdata_x)
	);

	gbcm_ram #(.WIDTH(VAL_W), .DEPTH(GRID_DEPTH)) u_grid_y (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (wdata_y),
		.rdata (rdata_y)
	);

	// weighted sum of the four corners, then round and saturate
	gbcm_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.rdata_x (rdata_x),
		.rdata_y (rdata_y),
		.push    (push),
		.result  (push_data)
	);

	// result queue, decouples the output side from the pipe
	gbcm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (m_accept),
		.not_empty (m_axis_tvalid),
		.head      (head)
	);

	assign m_axis_tdata = {head.y, head.x};
	assign m_axis_tuser = head.oor;

	`ASSERT_ALWAYS(a_pending_bound, pending_q <= OUTQ_CNT_W'(OUTQ_DEPTH))
	`ASSERT_ALWAYS(a_result_has_query, !m_axis_tvalid || (pending_q != '0))

endmodule

@@ sim/grid_bilinear_coord_map_tb.sv @@
`timescale 1ns / 1ps

module grid_bilinear_coord_map_tb;
	import gbcm_pkg::*;

	// run limits and pacing
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int SETTLE_CYCLES  = 16;     // well past the query latency
	localparam int RX_HOLD_CYCLES = 300;    // long receiver stall, fills the output queue
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 152;    // about 1830 random items over all phases
	localparam int SHOW_LIMIT     = 10;
	localparam int STEADY_PHASE   = 8;      // no idling on either side here
	localparam int HOLD_PHASE     = 9;      // receiver holds off at the start of this one

	// one input item, every field kept even when the command ignores it
	typedef struct {
		logic             cmd;
		logic [COL_W-1:0] node_col;
		logic [ROW_W-1:0] node_row;
		logic [VAL_W-1:0] node_x;
		logic [VAL_W-1:0] node_y;
		logic [VAL_W-1:0] query_x;
		logic [VAL_W-1:0] query_y;
	} grid_item_t;

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	// one line of the directed table
	typedef struct {
		row_kind_t            kind;
		grid_item_t           item;
		bit                   pinned;   // expected result typed in, not predicted
		result_t              want;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CNT_W-1:0]     reg_val;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CNT_W-1:0]      cfg_data;

	// shadow copy of both grid tables and of the count registers
	logic signed [VAL_W-1:0] grid_x_mem [GRID_DEPTH];
	logic signed [VAL_W-1:0] grid_y_mem [GRID_DEPTH];
	bit                      node_loaded [GRID_DEPTH];
	logic [CNT_W-1:0]        cols_model = COLUMNS_RESET;
	logic [CNT_W-1:0]        rows_model = ROWS_RESET;

	result_t   pending_maps [$];   // mapped coordinates still owed by the block
	plan_row_t plan [$];
	int        items_sent;
	int        fault_count;
	bit        steady;
	bit        rx_hold_req;

	grid_bilinear_coord_map u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// zero counts as one, anything past the table size saturates
	function automatic int active_count(input logic [CNT_W-1:0] v, input int limit);
		int n;
		n = (v == 0) ? 1 : int'(v);
		return (n > limit) ? limit : n;
	endfunction

	function automatic int node_addr(input int c, input int r);
		return c + r * MAX_COLUMNS;
	endfunction

	// clamp one axis into [0, (n-1)*256], flag it when it had to move
	function automatic int fit_axis(input logic [VAL_W-1:0] raw, input int n, inout logic oor);
		int q;
		int hi;
		q  = int'($signed(raw));
		hi = (n - 1) * 256;
		if (q < 0) begin
			oor = 1'b1;
			q   = 0;
		end else if (q > hi) begin
			oor = 1'b1;
			q   = hi;
		end
		return q;
	endfunction

	// base node, neighbor (held at the last column/row) and fractions of a query
	function automatic void locate(input logic [VAL_W-1:0] qx_raw, qy_raw,
			output int ul, ur, vl, vr, fu, fv, output logic oor);
		int nx;
		int ny;
		int qx;
		int qy;
		nx  = active_count(cols_model, MAX_COLUMNS);
		ny  = active_count(rows_model, MAX_ROWS);
		oor = 1'b0;
		qx  = fit_axis(qx_raw, nx, oor);
		qy  = fit_axis(qy_raw, ny, oor);
		ul  = qx >> FRAC_W;
		vl  = qy >> FRAC_W;
		fu  = qx & 255;
		fv  = qy & 255;
		ur  = (ul + 1 < nx) ? ul + 1 : nx - 1;
		vr  = (vl + 1 < ny) ? vl + 1 : ny - 1;
	endfunction

	// weighted sum is exact, then round half up and saturate
	function automatic logic [VAL_W-1:0] blend(input logic signed [VAL_W-1:0] v00, v01, v10, v11,
			input int fu, fv);
		longint acc;
		longint r;
		acc = longint'(v00) * (256 - fu) * (256 - fv)
			+ longint'(v01) * (256 - fu) * fv
			+ longint'(v10) * fu * (256 - fv)
			+ longint'(v11) * fu * fv;
		r = (acc + 32768) >>> 16;
		if (r > 32767) begin
			r = 32767;
		end else if (r < -32768) begin
			r = -32768;
		end
		return VAL_W'(r);
	endfunction

	function automatic result_t map_query(input logic [VAL_W-1:0] qx_raw, qy_raw);
		int      ul, ur, vl, vr, fu, fv;
		logic    oor;
		result_t r;
		locate(qx_raw, qy_raw, ul, ur, vl, vr, fu, fv, oor);
		r.x   = blend(grid_x_mem[node_addr(ul, vl)], grid_x_mem[node_addr(ul, vr)],
			grid_x_mem[node_addr(ur, vl)], grid_x_mem[node_addr(ur, vr)], fu, fv);
		r.y   = blend(grid_y_mem[node_addr(ul, vl)], grid_y_mem[node_addr(ul, vr)],
			grid_y_mem[node_addr(ur, vl)], grid_y_mem[node_addr(ur, vr)], fu, fv);
		r.oor = oor;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// drivers, all entered and left at a falling edge
	// ------------------------------------------------------------------

	// offer one item, wait for the handshake, then apply it to the shadow model
	task automatic send_item(input grid_item_t it, input bit pinned, input result_t want);
		if (!steady) begin
			while ($urandom_range(0, 99) < 26) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.cmd;
		// four zero bits fill the top bits above query_y
		s_axis_tdata  <= {4'b0, it.query_y, it.query_x, it.node_y, it.node_x,
			it.node_row, it.node_col};
		do @(posedge clk); while (!s_axis_tready);
		// expectations are pushed on the falling edge, clear of the checker
		@(negedge clk);
		items_sent++;
		if (it.cmd == CMD_WRITE) begin
			grid_x_mem[node_addr(it.node_col, it.node_row)]  = it.node_x;
			grid_y_mem[node_addr(it.node_col, it.node_row)]  = it.node_y;
			node_loaded[node_addr(it.node_col, it.node_row)] = 1'b1;
		end else begin
			pending_maps.push_back(pinned ? want : map_query(it.query_x, it.query_y));
		end
	endtask

	// stop offering, let every owed result drain, then let writes settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_maps.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_COLUMNS) begin
			cols_model = val;
		end else if (idx == REG_ROWS) begin
			rows_model = val;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// random content
	// ------------------------------------------------------------------

	function automatic grid_item_t random_item(input logic cmd);
		grid_item_t it;
		it.cmd      = cmd;
		it.node_col = COL_W'($urandom);
		it.node_row = ROW_W'($urandom);
		it.node_x   = VAL_W'($urandom);
		it.node_y   = VAL_W'($urandom);
		it.query_x  = VAL_W'($urandom);
		it.query_y  = VAL_W'($urandom);
		return it;
	endfunction

	// node values lean a little toward the signed extremes
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// mostly inside the grid, with exact nodes, the far edge and a bit past it,
	// just below zero and any 16 bit value mixed in
	function automatic logic [VAL_W-1:0] pick_axis(input int n);
		int hi;
		hi = (n - 1) * 256;
		case ($urandom_range(0, 19))
			0, 1, 2: return VAL_W'($urandom);
			3, 4:    return VAL_W'($urandom_range(0, n - 1) * 256);
			5:       return VAL_W'(hi);
			6:       return VAL_W'(hi + $urandom_range(1, 255));
			7:       return VAL_W'(-$urandom_range(1, 255));
			default: return VAL_W'($urandom_range(0, hi));
		endcase
	endfunction

	task automatic send_write(input int c, input int r);
		grid_item_t it;
		it          = random_item(CMD_WRITE);
		it.node_col = COL_W'(c);
		it.node_row = ROW_W'(r);
		it.node_x   = pick_value();
		it.node_y   = pick_value();
		send_item(it, 1'b0, '0);
	endtask

	task automatic send_query(input logic [VAL_W-1:0] qx, qy);
		int         ul, ur, vl, vr, fu, fv;
		logic       oor;
		grid_item_t it;
		// all four corners are read even at zero weight, so load any gap first
		locate(qx, qy, ul, ur, vl, vr, fu, fv, oor);
		if (!node_loaded[node_addr(ul, vl)]) send_write(ul, vl);
		if (!node_loaded[node_addr(ul, vr)]) send_write(ul, vr);
		if (!node_loaded[node_addr(ur, vl)]) send_write(ur, vl);
		if (!node_loaded[node_addr(ur, vr)]) send_write(ur, vr);
		it         = random_item(CMD_QUERY);
		it.query_x = qx;
		it.query_y = qy;
		send_item(it, 1'b0, '0);
	endtask

	// ------------------------------------------------------------------
	// directed table builders
	// ------------------------------------------------------------------

	function automatic void plan_write(input int c, r, input logic [VAL_W-1:0] x, y);
		plan_row_t row;
		row               = '{kind: ROW_ITEM, default: '0};
		row.kind          = ROW_ITEM;
		row.item          = random_item(CMD_WRITE);
		row.item.node_col = COL_W'(c);
		row.item.node_row = ROW_W'(r);
		row.item.node_x   = x;
		row.item.node_y   = y;
		plan.push_back(row);
	endfunction

	function automatic void plan_query(input logic [VAL_W-1:0] qx, qy);
		plan_row_t row;
		row              = '{kind: ROW_ITEM, default: '0};
		row.kind         = ROW_ITEM;
		row.item         = random_item(CMD_QUERY);
		row.item.query_x = qx;
		row.item.query_y = qy;
		plan.push_back(row);
	endfunction

	function automatic void plan_pinned(input logic [VAL_W-1:0] qx, qy, wx, wy, input logic woor);
		plan_row_t row;
		row              = '{kind: ROW_ITEM, default: '0};
		row.kind         = ROW_ITEM;
		row.item         = random_item(CMD_QUERY);
		row.item.query_x = qx;
		row.item.query_y = qy;
		row.pinned       = 1'b1;
		row.want.x       = wx;
		row.want.y       = wy;
		row.want.oor     = woor;
		plan.push_back(row);
	endfunction

	function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		plan_row_t row;
		row         = '{kind: ROW_CFG, default: '0};
		row.kind    = ROW_CFG;
		row.reg_idx = idx;
		row.reg_val = val;
		plan.push_back(row);
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------

	function automatic void log_fault(input string what, input result_t want, input result_t got);
		fault_count++;
		if (fault_count <= SHOW_LIMIT) begin
			$display("%0t %s: want x=%h y=%h oor=%b, got x=%h y=%h oor=%b", $time, what,
				want.x, want.y, want.oor, got.x, got.y, got.oor);
		end
	endfunction

	// each result item against the oldest owed one
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.x   = m_axis_tdata[VAL_W-1:0];
			got.y   = m_axis_tdata[2*VAL_W-1:VAL_W];
			got.oor = m_axis_tuser;
			if (pending_maps.size() == 0) begin
				log_fault("result with no query pending", '0, got);
			end else begin
				want = pending_maps.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.oor !== want.oor) begin
					log_fault("result mismatch", want, got);
				end
			end
		end
	end

	// receiver: random stalls, a steady stretch, and one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 26);
		end
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("grid_bilinear_coord_map_tb: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	initial begin
		plan_row_t row;
		int        nx;
		int        ny;
		int        start;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_WRITE;
		cfg_valid     = 1'b0;
		cfg_index     = REG_COLUMNS;
		cfg_data      = '0;
		steady        = 1'b0;
		rx_hold_req   = 1'b0;
		arst_n        = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 2x2 block at the origin with extreme entries, read at the reset size
		plan_write(0, 0, VAL_MAX, VAL_MIN);
		plan_write(1, 0, VAL_MIN, VAL_MAX);
		plan_write(0, 1, 16'h0100, 16'hFF00);
		plan_write(1, 1, 16'hFFFF, 16'h0001);
		plan_pinned(16'h0000, 16'h0000, VAL_MAX, VAL_MIN, 1'b0);
		// far below the grid clamps to the origin node
		plan_pinned(16'h8000, 16'h8000, VAL_MAX, VAL_MIN, 1'b1);
		plan_pinned(16'hFFFF, 16'h0000, VAL_MAX, VAL_MIN, 1'b1);
		plan_query(16'h0080, 16'h0080);
		plan_query(16'h00FF, 16'h0001);
		plan_query(16'h0001, 16'h00FF);
		// last corner: neighbor held on the last column and row
		plan_write(63, 63, VAL_MIN, VAL_MAX);
		plan_pinned(16'h7FFF, 16'h7FFF, VAL_MIN, VAL_MAX, 1'b1);
		plan_pinned(16'h3F00, 16'h3F00, VAL_MIN, VAL_MAX, 1'b0);
		plan_pinned(16'h3F01, 16'h3F00, VAL_MIN, VAL_MAX, 1'b1);
		// zero columns acts as one, oversized rows saturate
		plan_cfg(REG_COLUMNS, 7'd0);
		plan_cfg(REG_ROWS, 7'd127);
		plan_query(16'h0100, 16'h0080);
		// one row: linear along the bottom edge
		plan_cfg(REG_COLUMNS, 7'd127);
		plan_cfg(REG_ROWS, 7'd1);
		plan_query(16'h0040, 16'hFFFF);
		// 2x2 grid: far corner, exact last node, right edge and interior
		plan_cfg(REG_COLUMNS, 7'd2);
		plan_cfg(REG_ROWS, 7'd2);
		plan_pinned(16'h0180, 16'h0180, 16'hFFFF, 16'h0001, 1'b1);
		plan_pinned(16'h0100, 16'h0100, 16'hFFFF, 16'h0001, 1'b0);
		plan_query(16'h0100, 16'h0040);
		plan_query(16'h0040, 16'h00C0);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_CFG) begin
				cfg_write(row.reg_idx, row.reg_val);
			end else begin
				send_item(row.item, row.pinned, row.want);
			end
		end

		// random phases, each under its own grid size; corners are loaded on demand
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin nx = 1;   ny = 1;   end
				1: begin nx = 0;   ny = 0;   end
				2: begin nx = 2;   ny = 2;   end
				3: begin nx = 64;  ny = 64;  end
				4: begin nx = 127; ny = 127; end
				5: begin nx = 64;  ny = 2;   end
				6: begin nx = 2;   ny = 64;  end
				default: begin
					nx = $urandom_range(1, 9);
					ny = $urandom_range(1, 9);
				end
			endcase
			cfg_write(REG_COLUMNS, CNT_W'(nx));
			cfg_write(REG_ROWS, CNT_W'(ny));
			nx     = active_count(cols_model, MAX_COLUMNS);
			ny     = active_count(rows_model, MAX_ROWS);
			steady = (p == STEADY_PHASE);
			// receiver stalls while the sender keeps pushing queries
			if (p == HOLD_PHASE) begin
				rx_hold_req = 1'b1;
			end
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 65) begin
					send_query(pick_axis(nx), pick_axis(ny));
				end else if ($urandom_range(0, 1) == 0) begin
					send_write($urandom_range(0, nx - 1), $urandom_range(0, ny - 1));
				end else begin
					send_write($urandom_range(0, MAX_COLUMNS - 1), $urandom_range(0, MAX_ROWS - 1));
				end
			end
		end

		wait_idle();
		if (fault_count == 0 && pending_maps.size() == 0) begin
			$display("grid_bilinear_coord_map_tb: done, clean");
		end else begin
			$display("grid_bilinear_coord_map_tb: done, errors");
		end
		$finish;
	end

endmodule
